/* hdl/kbr_pkg.sv */
// Package for the button to keyboard report unit.
// Holds report layout types, HID usage constants and register indexes.
// No dependencies.
package kbr_pkg;

    localparam int NUM_SLOTS = 6;
    localparam int CFG_W     = 16;

    typedef logic [7:0] usage_t;

    // Same layout as a delivered report: modifiers in the low byte, then slot k.
    typedef struct packed {
        usage_t [NUM_SLOTS-1:0] slots;
        logic [7:0]             modifiers;
    } report_t;

    typedef struct packed {
        logic esc;
        logic enter;
    } press_t;

    typedef enum logic [1:0] {
        CFG_LONG_PRESS = 2'd0,
        CFG_HOME_MASK  = 2'd1,
        CFG_POWER_MASK = 2'd2
    } cfg_idx_t;

    localparam usage_t     USAGE_TAB   = 8'h2B;
    localparam usage_t     USAGE_ESC   = 8'h29;
    localparam usage_t     USAGE_ENTER = 8'h28;
    localparam logic [7:0] MOD_LSHIFT  = 8'h02;

    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd40;
    localparam logic [CFG_W-1:0] HOME_MASK_RESET  = 16'd2;
    localparam logic [CFG_W-1:0] POWER_MASK_RESET = 16'd1;

endpackage

/* hdl/kbr_cfg_regs.sv */
// Configuration registers of the button to keyboard report unit, APB-style port.
// Depends on kbr_pkg.
module kbr_cfg_regs
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output logic [kbr_pkg::CFG_W-1:0] long_press_ticks,
    output logic [kbr_pkg::CFG_W-1:0] home_mask,
    output logic [kbr_pkg::CFG_W-1:0] power_mask
);
    import kbr_pkg::*;

    logic [CFG_W-1:0] long_press_reg;
    logic [CFG_W-1:0] home_mask_reg;
    logic [CFG_W-1:0] power_mask_reg;
    logic             wr_en;
    cfg_idx_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = cfg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= LONG_PRESS_RESET;
            home_mask_reg  <= HOME_MASK_RESET;
            power_mask_reg <= POWER_MASK_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                CFG_LONG_PRESS: long_press_reg <= pwdata[CFG_W-1:0];
                CFG_HOME_MASK:  home_mask_reg  <= pwdata[CFG_W-1:0];
                CFG_POWER_MASK: power_mask_reg <= pwdata[CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            CFG_LONG_PRESS: prdata = {{(32-CFG_W){1'b0}}, long_press_reg};
            CFG_HOME_MASK:  prdata = {{(32-CFG_W){1'b0}}, home_mask_reg};
            CFG_POWER_MASK: prdata = {{(32-CFG_W){1'b0}}, power_mask_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign long_press_ticks = long_press_reg;
    assign home_mask        = home_mask_reg;
    assign power_mask       = power_mask_reg;

endmodule

/* hdl/kbr_press_track.sv */
// Power key press tracker: hold counter and long/short press decision.
// Depends on kbr_pkg.
module kbr_press_track #(
    parameter int HOLD_WIDTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      power_down,
    input  logic [kbr_pkg::CFG_W-1:0] long_press_ticks,
    output kbr_pkg::press_t           press
);
    import kbr_pkg::*;

    localparam int CMP_W = (HOLD_WIDTH > CFG_W) ? HOLD_WIDTH : CFG_W;

    logic                  was_down_reg;
    logic                  long_sent_reg;
    logic [HOLD_WIDTH-1:0] hold_reg;
    logic                  long_sent_next;
    logic [HOLD_WIDTH-1:0] hold_next;
    logic [HOLD_WIDTH-1:0] hold_inc;
    logic [HOLD_WIDTH-1:0] hold_down_next;
    logic                  is_long;

    assign hold_inc = (hold_reg == {HOLD_WIDTH{1'b1}}) ? hold_reg : hold_reg + 1'b1;

    // Counter value for a tick on which the power key is down.
    assign hold_down_next = was_down_reg ? hold_inc : '0;
    assign is_long        = CMP_W'(hold_down_next) >= CMP_W'(long_press_ticks);

    always_comb
    begin
        hold_next      = hold_reg;
        long_sent_next = long_sent_reg;
        press.esc      = 1'b0;
        press.enter    = 1'b0;
        if (power_down)
        begin
            hold_next      = hold_down_next;
            long_sent_next = was_down_reg ? long_sent_reg : 1'b0;
            // Escape repeats on every tick once the threshold is reached.
            if (is_long)
            begin
                long_sent_next = 1'b1;
                press.esc      = 1'b1;
            end
        end
        else if (was_down_reg)
        begin
            // A release that never reached the threshold is a short press.
            press.enter    = !long_sent_reg;
            hold_next      = '0;
            long_sent_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_down_reg  <= 1'b0;
            long_sent_reg <= 1'b0;
            hold_reg      <= '0;
        end
        else if (advance)
        begin
            was_down_reg  <= power_down;
            long_sent_reg <= long_sent_next;
            hold_reg      <= hold_next;
        end
    end

endmodule

/* hdl/kbr_report_build.sv */
// Report builder: fills key slots and filters reports equal to the last delivered one.
// Depends on kbr_pkg.
module kbr_report_build #(
    parameter int KEY_SLOTS = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              tab_down,
    input  logic              home_down,
    input  kbr_pkg::press_t   press,
    input  logic              reader_waiting,
    output kbr_pkg::report_t  report,
    output logic              deliver,
    output logic              have_last,
    output kbr_pkg::report_t  last_delivered
);
    import kbr_pkg::*;

    logic       tab_use;
    logic [2:0] pos_esc;
    logic [2:0] pos_enter;
    logic       have_last_reg;
    report_t    last_reg;

    assign tab_use   = tab_down || home_down;
    assign pos_esc   = {2'b00, tab_use};
    assign pos_enter = {2'b00, tab_use} + {2'b00, press.esc};

    // Usages are distinct and slots start empty, so filling is a compaction
    // in the order Tab, Escape, Enter.
    always_comb
    begin
        report.modifiers = home_down ? MOD_LSHIFT : 8'h00;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            report.slots[k] = 8'h00;
            if (k < KEY_SLOTS)
            begin
                if (tab_use && (k == 0))
                    report.slots[k] = USAGE_TAB;
                else if (press.esc && (pos_esc == 3'(k)))
                    report.slots[k] = USAGE_ESC;
                else if (press.enter && (pos_enter == 3'(k)))
                    report.slots[k] = USAGE_ENTER;
            end
        end
    end

    assign deliver = reader_waiting && !(have_last_reg && (report == last_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_last_reg <= 1'b0;
            last_reg      <= '0;
        end
        else if (advance && deliver)
        begin
            have_last_reg <= 1'b1;
            last_reg      <= report;
        end
    end

    assign have_last      = have_last_reg;
    assign last_delivered = last_reg;

endmodule

/* hdl/button_to_keyboard_report_unit.sv */
// Top level of the button to keyboard report unit.
// Depends on kbr_pkg, kbr_cfg_regs, kbr_press_track and kbr_report_build.

// Each input item is one poll tick and yields exactly one result item: the current
// keyboard report and a deliver flag that is set when the report differs from the
// last one delivered and a reader is waiting. The unit takes one item per clock
// cycle unless the result register is stalled; an item passes through an input
// register and then the result register. The power-press state (hold counter,
// long-press flag) and the last delivered report are updated in the same cycle as
// the item that changes them, which is what lets the next item follow immediately.
// Configuration registers sit at byte addresses 0, 4 and 8 and should be written
// only while idle.
module button_to_keyboard_report_unit #(
    parameter int HOLD_WIDTH = 16,
    parameter int KEY_SLOTS  = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: tab_level[0], pmic_ok[1], pmic_status[17:2], reader_waiting[18]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // m_tdata: modifiers[7:0], key_slot0..key_slot5[55:8], deliver[56]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kbr_pkg::*;

    logic [CFG_W-1:0] long_press_ticks;
    logic [CFG_W-1:0] home_mask;
    logic [CFG_W-1:0] power_mask;

    logic             in_valid_reg;
    logic             tab_level_reg;
    logic             pmic_ok_reg;
    logic [15:0]      pmic_status_reg;
    logic             reader_waiting_reg;

    logic             out_valid_reg;
    report_t          out_report_reg;
    logic             out_deliver_reg;

    logic             out_free;
    logic             advance;
    logic             tab_down;
    logic             home_down;
    logic             power_down;
    press_t           press;
    report_t          report;
    logic             deliver;
    logic             have_last;
    report_t          last_delivered;

    kbr_cfg_regs u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .long_press_ticks (long_press_ticks),
        .home_mask        (home_mask),
        .power_mask       (power_mask)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            tab_level_reg      <= s_tdata[0];
            pmic_ok_reg        <= s_tdata[1];
            pmic_status_reg    <= s_tdata[17:2];
            reader_waiting_reg <= s_tdata[18];
        end
    end

    // A failed status read counts both power-chip keys as released.
    assign tab_down   = !tab_level_reg;
    assign home_down  = pmic_ok_reg && ((pmic_status_reg & home_mask) == '0);
    assign power_down = pmic_ok_reg && ((pmic_status_reg & power_mask) == '0);

    kbr_press_track #(
        .HOLD_WIDTH (HOLD_WIDTH)
    ) u_press (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .power_down       (power_down),
        .long_press_ticks (long_press_ticks),
        .press            (press)
    );

    kbr_report_build #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_report (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .tab_down       (tab_down),
        .home_down      (home_down),
        .press          (press),
        .reader_waiting (reader_waiting_reg),
        .report         (report),
        .deliver        (deliver),
        .have_last      (have_last),
        .last_delivered (last_delivered)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_report_reg  <= report;
            out_deliver_reg <= deliver;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_deliver_reg, out_report_reg};

`ifndef NO_ASSERTIONS
    a_last_follows_delivery: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && deliver) |=> (have_last && (last_delivered == $past(report))))
        else $error("last delivered report does not match the report just delivered");

    a_esc_enter_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(press.esc && press.enter))
        else $error("Escape and Enter raised for the same tick");

    a_result_tracks_delivery: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && deliver) |=> (m_tvalid && m_tdata[56]))
        else $error("delivered report not flagged in the result register");
`endif

endmodule

/* dv/kbr_report_checker.sv */
// Checker for the button to keyboard report unit: watches the item and register ports,
// predicts every report from its own copy of the press state and compares field by field.
// Depends on kbr_pkg.
`timescale 1ns / 1ps

module kbr_report_checker #(
    parameter int HOLD_WIDTH = 16,
    parameter int KEY_SLOTS  = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // s_tdata: tab_level[0], pmic_ok[1], pmic_status[17:2], reader_waiting[18]
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: modifiers[7:0], key_slot0..key_slot5[55:8], deliver[56]
    input  logic [63:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          reports_due
);
    import kbr_pkg::*;

    localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = '1;

    typedef struct packed {
        logic    deliver;
        report_t report;
    } tick_result_t;

    tick_result_t expected_reports[$];

    logic [CFG_W-1:0]      long_press_ticks;
    logic [CFG_W-1:0]      home_mask;
    logic [CFG_W-1:0]      power_mask;
    logic                  power_was_down;
    logic                  long_sent;
    logic                  enter_pending;
    logic                  have_last;
    logic [HOLD_WIDTH-1:0] hold_count;
    report_t               last_delivered;
    int                    failures = 0;

    // A usage goes into the first free slot unless it is already there.
    function automatic report_t with_usage(report_t r, usage_t u);
        logic placed;
        placed = 1'b0;
        for (int i = 0; i < KEY_SLOTS && i < NUM_SLOTS; i++)
        begin
            if (!placed && (r.slots[i] == u || r.slots[i] == '0))
            begin
                r.slots[i] = u;
                placed     = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic predict_tick(input logic [23:0] d);
        report_t      rep;
        tick_result_t res;
        logic [15:0]  status;
        logic         tab_down;
        logic         home_down;
        logic         power_down;
        status     = d[17:2];
        tab_down   = !d[0];
        home_down  = d[1] && ((status & home_mask) == '0);
        power_down = d[1] && ((status & power_mask) == '0);
        rep        = '0;

        if (tab_down || home_down)
            rep = with_usage(rep, USAGE_TAB);
        if (home_down)
            rep.modifiers = MOD_LSHIFT;

        if (power_down)
        begin
            if (!power_was_down)
            begin
                hold_count = '0;
                long_sent  = 1'b0;
            end
            else if (hold_count != HOLD_MAX)
                hold_count = hold_count + 1'b1;
            if (hold_count >= long_press_ticks)
            begin
                long_sent = 1'b1;
                rep       = with_usage(rep, USAGE_ESC);
            end
        end
        else if (power_was_down)
        begin
            if (!long_sent)
                enter_pending = 1'b1;
            hold_count = '0;
            long_sent  = 1'b0;
        end
        power_was_down = power_down;

        if (enter_pending)
        begin
            rep           = with_usage(rep, USAGE_ENTER);
            enter_pending = 1'b0;
        end

        res.report  = rep;
        res.deliver = !(have_last && rep == last_delivered) && d[18];
        if (res.deliver)
        begin
            last_delivered = rep;
            have_last      = 1'b1;
        end
        expected_reports.push_back(res);
    endtask

    task automatic note_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
        failures++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tick_result_t want;
        report_t      got;
        if (!rst_n)
        begin
            long_press_ticks = LONG_PRESS_RESET;
            home_mask        = HOME_MASK_RESET;
            power_mask       = POWER_MASK_RESET;
            power_was_down   = 1'b0;
            long_sent        = 1'b0;
            enter_pending    = 1'b0;
            have_last        = 1'b0;
            hold_count       = '0;
            last_delivered   = '0;
            expected_reports.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (cfg_idx_t'(paddr[3:2]))
                    CFG_LONG_PRESS: long_press_ticks = pwdata[CFG_W-1:0];
                    CFG_HOME_MASK:  home_mask        = pwdata[CFG_W-1:0];
                    CFG_POWER_MASK: power_mask       = pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end

            // Predict before checking, so that even a pass-through result finds its item.
            if (s_tvalid && s_tready)
                predict_tick(s_tdata);

            if (m_tvalid && m_tready)
            begin
                got = m_tdata[55:0];
                if (expected_reports.size() == 0)
                begin
                    failures++;
                    $display("%0t: report %h with no item waiting", $time, m_tdata);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.modifiers != want.report.modifiers)
                        note_mismatch("modifiers", want.report.modifiers, got.modifiers);
                    for (int k = 0; k < NUM_SLOTS; k++)
                    begin
                        if (got.slots[k] != want.report.slots[k])
                            note_mismatch($sformatf("key_slot%0d", k),
                                          want.report.slots[k], got.slots[k]);
                    end
                    if (m_tdata[56] != want.deliver)
                        note_mismatch("deliver", {7'd0, want.deliver}, {7'd0, m_tdata[56]});
                end
            end
        end
        fail_count  <= failures;
        reports_due <= expected_reports.size();
    end

endmodule

/* dv/button_to_keyboard_report_unit_test.sv */
// Top of the button to keyboard report unit testbench: clock, reset, register writes,
// poll-tick stimulus under several idling patterns, and the verdict.
// Depends on kbr_pkg, kbr_report_checker and the unit itself.
`timescale 1ns / 1ps

module button_to_keyboard_report_unit_test;
    import kbr_pkg::*;

    localparam int CYCLE_LIMIT     = 40000;
    localparam int LONG_HOLD_TICKS = 100;
    localparam int RANDOM_TICKS    = 400;
    localparam int LONG_STALL      = 300;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int reports_due;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int long_stall_ask = 0;
    int power_left;
    int home_left;

    logic [CFG_W-1:0] cur_threshold;
    logic [CFG_W-1:0] cur_home_mask;
    logic [CFG_W-1:0] cur_power_mask;

    button_to_keyboard_report_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    kbr_report_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .reports_due (reports_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("button_to_keyboard_report_unit_test NOT OK");
        $finish;
    end

    // Result side. A raised long_stall_ask starts a hold-off that this process counts out.
    initial
    begin : result_side
        int stall_left;
        int stalls_done;
        stall_left  = 0;
        stalls_done = 0;
        m_tready    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && stalls_done != long_stall_ask)
            begin
                stalls_done++;
                stall_left = LONG_STALL;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [23:0] tick_item(logic tab_level, logic pmic_ok,
                                              logic [15:0] status, logic reader);
        return {5'd0, reader, status, pmic_ok, tab_level};
    endfunction

    // Sampling s_tready at the falling edge gives the value seen at the next rising edge.
    task automatic send_tick(input logic [23:0] d);
        logic rdy;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end while (!rdy);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        logic rdy;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            rdy = pready;
            @(posedge clk);
        end while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_W-1:0] threshold, input logic [CFG_W-1:0] hmask,
                              input logic [CFG_W-1:0] pmask);
        cur_threshold  = threshold;
        cur_home_mask  = hmask;
        cur_power_mask = pmask;
        cfg_write(CFG_LONG_PRESS, threshold);
        cfg_write(CFG_HOME_MASK, hmask);
        cfg_write(CFG_POWER_MASK, pmask);
    endtask

    function automatic logic [CFG_W-1:0] random_mask();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        else if (pick < 6)
            return 16'd1 << $urandom_range(15);
        else
            return (16'd1 << $urandom_range(15)) | (16'd1 << $urandom_range(15));
    endfunction

    // Random bits, with the lowest mask bit forced up for a released key and the whole
    // mask cleared for a pressed one, so that the intended press mostly holds.
    function automatic logic [15:0] status_for(logic home_dn, logic power_dn);
        logic [15:0] s;
        s = 16'($urandom);
        if (!home_dn)
            s = s | (cur_home_mask & (~cur_home_mask + 16'd1));
        if (!power_dn)
            s = s | (cur_power_mask & (~cur_power_mask + 16'd1));
        if (home_dn)
            s = s & ~cur_home_mask;
        if (power_dn)
            s = s & ~cur_power_mask;
        return s;
    endfunction

    task automatic random_tick();
        int   lim;
        logic home_dn;
        logic power_dn;
        if ($urandom_range(9) == 0)
            send_tick({5'd0, 19'($urandom)});
        else
        begin
            // Lengths straddle a nonzero threshold, so short and long presses both occur.
            if (power_left == 0 && $urandom_range(3) == 0)
            begin
                lim        = (cur_threshold > 40) ? 40 : int'(cur_threshold);
                power_left = $urandom_range(lim + 4, 1);
            end
            if (home_left == 0 && $urandom_range(5) == 0)
                home_left = $urandom_range(8, 1);
            power_dn = (power_left != 0);
            home_dn  = (home_left != 0);
            if (power_left != 0)
                power_left--;
            if (home_left != 0)
                home_left--;
            send_tick(tick_item($urandom_range(9) >= 3, $urandom_range(19) != 0,
                                status_for(home_dn, power_dn), $urandom_range(9) >= 3));
        end
    endtask

    initial
    begin : stimulus
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        rst_n      = 1'b0;
        power_left = 0;
        home_left  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short threshold so that short and long power presses fit in a few ticks.
        set_config(16'd3, 16'h0002, 16'h0001);
        send_tick(tick_item(1'b1, 1'b1, 16'hFFFF, 1'b1));
        send_tick(tick_item(1'b1, 1'b1, 16'hFFFF, 1'b1));
        send_tick(tick_item(1'b0, 1'b1, 16'hFFFF, 1'b1));
        send_tick(tick_item(1'b1, 1'b1, 16'hFFFD, 1'b1));
        send_tick(tick_item(1'b0, 1'b1, 16'hFFFD, 1'b0));
        send_tick(tick_item(1'b1, 1'b0, 16'h0000, 1'b1));
        send_tick(tick_item(1'b1, 1'b1, 16'hFFFE, 1'b1));
        send_tick(tick_item(1'b1, 1'b1, 16'hFFFE, 1'b1));
        send_tick(tick_item(1'b1, 1'b1, 16'hFFFF, 1'b1));
        send_tick(tick_item(1'b1, 1'b1, 16'hFFFF, 1'b1));
        repeat (5)
            send_tick(tick_item(1'b0, 1'b1, 16'h0000, 1'b1));
        send_tick(tick_item(1'b1, 1'b1, 16'hFFFF, 1'b0));
        send_tick(tick_item(1'b1, 1'b1, 16'hFFFF, 1'b1));
        send_tick(tick_item(1'b0, 1'b1, 16'h0000, 1'b1));
        // A failed status read ends the press, which was short, so Enter follows.
        send_tick(tick_item(1'b1, 1'b0, 16'h0000, 1'b1));
        send_tick(tick_item(1'b1, 1'b1, 16'hFFFF, 1'b0));
        send_tick(tick_item(1'b1, 1'b1, 16'hFFFF, 1'b1));
        send_tick(tick_item(1'b0, 1'b1, 16'hFFFE, 1'b1));
        drain();

        // Zero masks and threshold: both keys are down whenever the read succeeds.
        set_config(16'd0, 16'h0000, 16'h0000);
        repeat (3)
            send_tick(tick_item(1'b1, 1'b1, 16'($urandom), 1'b1));
        send_tick(tick_item(1'b1, 1'b0, 16'hFFFF, 1'b1));
        send_tick(tick_item(1'b0, 1'b1, 16'hFFFF, 1'b1));
        drain();

        // Hold the power key well past the threshold so that Escape repeats on every tick.
        set_config(16'd64, 16'hFFFF, 16'h0001);
        for (int i = 0; i < LONG_HOLD_TICKS; i++)
            send_tick(tick_item(1'($urandom), 1'b1, 16'($urandom) & 16'hFFFE, 1'($urandom)));
        send_tick(tick_item(1'b1, 1'b1, 16'hFFFF, 1'b1));
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_config(16'd5, 16'h0002, 16'h0001);
                1: set_config(16'd0, 16'hFFFF, 16'd1 << $urandom_range(15));
                2: set_config(16'($urandom_range(20)), random_mask(), random_mask());
                default: set_config(16'($urandom_range(12, 1)), random_mask(), random_mask());
            endcase
            send_idle_pct  = (phase == 1) ? 67 : (phase == 3) ? 24 : 0;
            recv_stall_pct = (phase == 2) ? 67 : (phase == 3) ? 24 : 0;
            power_left     = 0;
            home_left      = 0;
            for (int i = 0; i < RANDOM_TICKS; i++)
            begin
                if (phase == 0 && i == 100)
                    long_stall_ask <= long_stall_ask + 1;
                if (phase == 3 && i == RANDOM_TICKS / 2)
                    drain();
                random_tick();
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && reports_due == 0)
            $display("button_to_keyboard_report_unit_test OK");
        else
            $display("button_to_keyboard_report_unit_test NOT OK");
        $finish;
    end

endmodule
